>>> hw/rtl/psdc_pkg.sv
package psdc_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [7:0]  STARTUP_LEVEL      = 8'd26;
    localparam logic [15:0] START_DELAY_TICKS  = 16'd940;
    localparam logic [7:0]  RAMP_STEP_TICKS    = 8'd10;
    localparam logic [7:0]  DIM_STEP_TICKS     = 8'd10;
    localparam logic [15:0] RESEND_TICKS       = 16'd100;
    localparam logic [15:0] PRESS_WINDOW_TICKS = 16'd1500;
    localparam logic [15:0] INIT_TICKS         = 16'd1000;
    localparam logic [7:0]  SLAVE_RELAY_ON     = 8'd10;
    localparam logic [7:0]  SLAVE_RELAY_OFF    = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLAVE_MODE = 3'd0,
        REG_MAX_LEVEL  = 3'd1,
        REG_MIN_LEVEL  = 3'd2,
        REG_RAMP_TIME  = 3'd3,
        REG_DIM_TIME   = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        PH_OFF      = 4'd0,
        PH_PRESS    = 4'd1,
        PH_START    = 4'd2,
        PH_RISE     = 4'd3,
        PH_ON       = 4'd4,
        PH_HOLD     = 4'd5,
        PH_FALL     = 4'd6,
        PH_PICK     = 4'd7,
        PH_UP       = 4'd8,
        PH_DOWN     = 4'd9,
        PH_SLV_INIT = 4'd10,
        PH_SLAVE    = 4'd11,
        PH_INIT     = 4'd12,
        PH_UPDATE   = 4'd13
    } phase_t;

endpackage

>>> hw/rtl/push_switch_dimmer_controller.sv
// channel | direction | handshake              | payload
// s       | in        | s_tvalid / s_tready    | s_tdata, s_tuser (one item per 1 ms tick)
// m       | out       | m_tvalid / m_tready    | m_tdata (one result per item)
// cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// an item is registered on input, then stepped through the phase logic into
// the result register, which raises m_tvalid; one item per cycle sustained
// while the m side does not stall
// cfg_ready is always high; a write takes effect on the next stepped item
// rst_n clears all control and phase state at once, no clearing pass
// a stalled m side holds the result and the input register, then s_tready drops
module push_switch_dimmer_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] switch_pressed, [8:1] packet_level, [15:9] zero
    input  logic [psdc_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] packet_arrived
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] level_out, [8] level_written, [9] relay_closed, [10] send_frame,
    // [18:11] frame_level, [22:19] phase, [23] zero
    output logic [psdc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psdc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import psdc_pkg::*;

    // configuration
    logic        slave_mode_reg;
    logic [7:0]  max_level_reg;
    logic [7:0]  min_level_reg;
    logic [15:0] ramp_time_reg;
    logic [15:0] dim_time_reg;

    // controller state
    phase_t      phase_reg, phase_next;
    logic [7:0]  cur_reg, cur_next;
    logic [7:0]  rem_reg, rem_next;
    logic        dir_up_reg, dir_up_next;
    logic [15:0] step_reg, step_next;
    logic [15:0] resend_reg, resend_next;
    logic        relay_reg, relay_next;
    logic [7:0]  frame_reg, frame_next;
    logic [7:0]  drive_reg, drive_next;
    logic        wrote, sent;

    // input and result registers
    logic        in_valid_reg;
    logic        in_sw_reg;
    logic        in_pkt_reg;
    logic [7:0]  in_lev_reg;
    logic        out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic        s_take;
    logic        adv;
    logic        cfg_take;
    logic [15:0] ramp_period;
    logic [15:0] dim_period;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign adv       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign s_take    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign ramp_period = (ramp_time_reg > 16'd255) ? {8'd0, ramp_time_reg[15:8]}
                                                   : {8'd0, RAMP_STEP_TICKS};
    assign dim_period  = (dim_time_reg > 16'd255) ? {8'd0, dim_time_reg[15:8]}
                                                  : {8'd0, DIM_STEP_TICKS};

    always_comb
    begin
        phase_next  = phase_reg;
        cur_next    = cur_reg;
        rem_next    = rem_reg;
        dir_up_next = dir_up_reg;
        relay_next  = relay_reg;
        frame_next  = frame_reg;
        drive_next  = drive_reg;
        wrote       = 1'b0;
        sent        = 1'b0;
        // timers count down first, holding at zero
        step_next   = (step_reg != 16'd0) ? step_reg - 16'd1 : step_reg;
        resend_next = (resend_reg != 16'd0) ? resend_reg - 16'd1 : resend_reg;

        unique case (phase_reg)
            PH_UPDATE:
            begin
                if (slave_mode_reg)
                begin
                    phase_next = PH_SLV_INIT;
                end
                else
                begin
                    dir_up_next = 1'b0;
                    rem_next    = max_level_reg;
                    phase_next  = PH_OFF;
                end
            end
            PH_OFF:
            begin
                if (in_sw_reg)
                begin
                    step_next  = PRESS_WINDOW_TICKS;
                    phase_next = PH_PRESS;
                end
            end
            PH_PRESS:
            begin
                if (!in_sw_reg)
                begin
                    relay_next = 1'b1;
                    if (rem_reg >= STARTUP_LEVEL)
                    begin
                        phase_next = PH_RISE;
                        step_next  = 16'd0;
                    end
                    else
                    begin
                        cur_next    = STARTUP_LEVEL;
                        drive_next  = STARTUP_LEVEL;
                        wrote       = 1'b1;
                        frame_next  = STARTUP_LEVEL;
                        sent        = 1'b1;
                        resend_next = RESEND_TICKS;
                        step_next   = START_DELAY_TICKS;
                        phase_next  = PH_START;
                    end
                end
            end
            PH_START:
            begin
                if (step_next == 16'd0)
                begin
                    step_next = {8'd0, RAMP_STEP_TICKS};
                    if (cur_reg != rem_reg)
                    begin
                        cur_next    = (cur_reg < rem_reg) ? cur_reg + 8'd1 : cur_reg - 8'd1;
                        frame_next  = cur_next;
                        drive_next  = cur_next;
                        wrote       = 1'b1;
                        sent        = 1'b1;
                        resend_next = RESEND_TICKS;
                    end
                    else
                    begin
                        phase_next = PH_ON;
                    end
                end
            end
            PH_RISE:
            begin
                if (step_next == 16'd0)
                begin
                    step_next = ramp_period;
                    if (cur_reg < rem_reg && cur_reg < max_level_reg)
                    begin
                        drive_next  = cur_reg;
                        frame_next  = cur_reg;
                        wrote       = 1'b1;
                        sent        = 1'b1;
                        resend_next = RESEND_TICKS;
                        cur_next    = cur_reg + 8'd1;
                    end
                    else
                    begin
                        phase_next = PH_ON;
                    end
                end
            end
            PH_ON:
            begin
                if (in_sw_reg)
                begin
                    step_next  = PRESS_WINDOW_TICKS;
                    phase_next = PH_HOLD;
                end
            end
            PH_HOLD:
            begin
                // short release switches off, a press outliving the window dims
                if (!in_sw_reg && step_next != 16'd0)
                begin
                    rem_next   = cur_reg;
                    phase_next = PH_FALL;
                    step_next  = {8'd0, DIM_STEP_TICKS};
                end
                if (step_next == 16'd0)
                begin
                    phase_next = PH_PICK;
                end
            end
            PH_FALL:
            begin
                if (step_next == 16'd0)
                begin
                    step_next   = ramp_period;
                    frame_next  = cur_reg;
                    wrote       = 1'b1;
                    sent        = 1'b1;
                    resend_next = RESEND_TICKS;
                    if (cur_reg != 8'd0)
                    begin
                        drive_next = cur_reg;
                        cur_next   = cur_reg - 8'd1;
                    end
                    else
                    begin
                        drive_next = 8'd0;
                        phase_next = PH_OFF;
                        relay_next = 1'b0;
                    end
                end
            end
            PH_PICK:
            begin
                phase_next = dir_up_reg ? PH_UP : PH_DOWN;
            end
            PH_UP:
            begin
                if (step_next == 16'd0)
                begin
                    step_next = dim_period;
                    if (in_sw_reg)
                    begin
                        if (cur_reg < max_level_reg)
                        begin
                            cur_next    = cur_reg + 8'd1;
                            frame_next  = cur_next;
                            drive_next  = cur_next;
                            wrote       = 1'b1;
                            sent        = 1'b1;
                            resend_next = RESEND_TICKS;
                        end
                    end
                    else
                    begin
                        if (cur_reg >= max_level_reg)
                        begin
                            dir_up_next = 1'b0;
                        end
                        phase_next = PH_ON;
                    end
                end
            end
            PH_DOWN:
            begin
                if (step_next == 16'd0)
                begin
                    step_next = dim_period;
                    if (in_sw_reg)
                    begin
                        if (cur_reg > min_level_reg)
                        begin
                            cur_next    = cur_reg - 8'd1;
                            frame_next  = cur_next;
                            drive_next  = cur_next;
                            wrote       = 1'b1;
                            sent        = 1'b1;
                            resend_next = RESEND_TICKS;
                        end
                    end
                    else
                    begin
                        if (cur_reg <= min_level_reg)
                        begin
                            dir_up_next = 1'b1;
                        end
                        phase_next = PH_ON;
                    end
                end
            end
            PH_SLV_INIT:
            begin
                phase_next = PH_SLAVE;
            end
            PH_SLAVE:
            begin
                if (in_pkt_reg)
                begin
                    drive_next = in_lev_reg;
                    cur_next   = in_lev_reg;
                    wrote      = 1'b1;
                end
                // hysteresis band keeps the relay as it is
                if (cur_next > SLAVE_RELAY_ON)
                begin
                    relay_next = 1'b1;
                end
                else if (cur_next < SLAVE_RELAY_OFF)
                begin
                    relay_next = 1'b0;
                end
            end
            default:
            begin
                // after reset, and for any code with no meaning
                step_next = INIT_TICKS;
                if (slave_mode_reg)
                begin
                    phase_next = PH_SLV_INIT;
                end
                else
                begin
                    dir_up_next = 1'b0;
                    rem_next    = max_level_reg;
                    phase_next  = PH_OFF;
                end
            end
        endcase

        if (!slave_mode_reg && resend_next == 16'd0)
        begin
            sent        = 1'b1;
            resend_next = RESEND_TICKS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_mode_reg <= 1'b0;
            max_level_reg  <= 8'd255;
            min_level_reg  <= 8'd0;
            ramp_time_reg  <= 16'd0;
            dim_time_reg   <= 16'd0;
            phase_reg      <= PH_INIT;
            cur_reg        <= 8'd0;
            rem_reg        <= 8'd255;
            dir_up_reg     <= 1'b0;
            step_reg       <= 16'd0;
            resend_reg     <= 16'd0;
            relay_reg      <= 1'b0;
            frame_reg      <= 8'd0;
            drive_reg      <= 8'd0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // a mode write restarts the phase logic
            if (cfg_take && cfg_index == REG_SLAVE_MODE)
            begin
                phase_reg <= PH_UPDATE;
            end
            else if (adv)
            begin
                phase_reg <= phase_next;
            end
            if (adv)
            begin
                cur_reg    <= cur_next;
                rem_reg    <= rem_next;
                dir_up_reg <= dir_up_next;
                step_reg   <= step_next;
                resend_reg <= resend_next;
                relay_reg  <= relay_next;
                frame_reg  <= frame_next;
                drive_reg  <= drive_next;
            end
            if (cfg_take)
            begin
                unique case (cfg_index)
                    REG_SLAVE_MODE: slave_mode_reg <= cfg_data[0];
                    REG_MAX_LEVEL:  max_level_reg  <= cfg_data[7:0];
                    REG_MIN_LEVEL:  min_level_reg  <= cfg_data[7:0];
                    REG_RAMP_TIME:  ramp_time_reg  <= cfg_data;
                    REG_DIM_TIME:   dim_time_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (s_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_sw_reg  <= s_tdata[0];
            in_lev_reg <= s_tdata[8:1];
            in_pkt_reg <= s_tuser;
        end
        if (adv)
        begin
            out_data_reg <= {1'b0, phase_next, frame_next, sent, relay_next, wrote,
                             drive_next};
        end
    end

endmodule

>>> hw/rtl/psdc_checker.sv
module psdc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [psdc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import psdc_pkg::*;

    logic [7:0] level_out;
    logic       level_written;
    logic       relay_closed;
    logic       send_frame;
    logic [7:0] frame_level;
    logic [3:0] phase;

    assign level_out     = m_tdata[7:0];
    assign level_written = m_tdata[8];
    assign relay_closed  = m_tdata[9];
    assign send_frame    = m_tdata[10];
    assign frame_level   = m_tdata[18:11];
    assign phase         = m_tdata[22:19];

    // a stalled result stays offered and unchanged
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // in master mode every driver write goes out in a frame at the same level
    a_write_framed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && level_written && phase != PH_SLAVE
        |-> send_frame && frame_level == level_out)
        else $error("driver write without matching frame");

    // the relay is closed throughout start-up and ramp up
    a_relay_rising: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (phase == PH_START || phase == PH_RISE) |-> relay_closed)
        else $error("relay open while ramping up");

endmodule

bind push_switch_dimmer_controller psdc_checker u_psdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
